@@ rtl/core/shc_pkg.sv @@
package shc_pkg;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [6:0] LAST_ROUND = 7'd79;
	localparam logic [6:0] ROUND_20   = 7'd20;
	localparam logic [6:0] ROUND_40   = 7'd40;
	localparam logic [6:0] ROUND_60   = 7'd60;
	localparam logic [2:0] LAST_WIDX  = 3'd4;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] END_POS    = 6'd63;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_PAD80,
		SRC_ZERO,
		SRC_LEN
	} src_t;

	typedef enum logic [1:0] {
		PH_CH,
		PH_PAR1,
		PH_MAJ,
		PH_PAR2
	} phase_t;

	typedef struct packed {
		logic   shift;
		src_t   src;
		logic   len_inc;
		logic   blen_load;
		logic   round_load;
		logic   round_en;
		phase_t phase;
		logic   chain_add;
		logic   chain_init;
		logic [2:0] widx;
	} cmd_t;

	typedef struct packed {
		logic pos_wrap;
		logic pos_56;
	} sts_t;

endpackage

@@ rtl/core/shc_ctrl.sv @@
module shc_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         byte_valid,
	input  logic         last,
	output logic         out_valid,
	input  logic         out_ready,
	input  shc_pkg::sts_t sts,
	output shc_pkg::cmd_t cmd
);
	import shc_pkg::*;

	state_t     st_q, st_d;
	logic [6:0] rnd_q, rnd_d;
	logic [2:0] widx_q, widx_d;
	logic       pad_q, pad_d;
	logic       sent80_q, sent80_d;
	logic       fin_q, fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			rnd_q    <= '0;
			widx_q   <= '0;
			pad_q    <= 1'b0;
			sent80_q <= 1'b0;
			fin_q    <= 1'b0;
		end else begin
			st_q     <= st_d;
			rnd_q    <= rnd_d;
			widx_q   <= widx_d;
			pad_q    <= pad_d;
			sent80_q <= sent80_d;
			fin_q    <= fin_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		rnd_d     = rnd_q;
		widx_d    = widx_q;
		pad_d     = pad_q;
		sent80_d  = sent80_q;
		fin_d     = fin_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		cmd.src   = SRC_DATA;
		cmd.widx  = widx_q;

		if (rnd_q < ROUND_20) begin
			cmd.phase = PH_CH;
		end else if (rnd_q < ROUND_40) begin
			cmd.phase = PH_PAR1;
		end else if (rnd_q < ROUND_60) begin
			cmd.phase = PH_MAJ;
		end else begin
			cmd.phase = PH_PAR2;
		end

		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					pad_d = last;
					if (byte_valid) begin
						cmd.shift   = 1'b1;
						cmd.src     = SRC_DATA;
						cmd.len_inc = 1'b1;
					end
					if (byte_valid && sts.pos_wrap) begin
						cmd.round_load = 1'b1;
						st_d           = ST_ROUND;
					end else if (last) begin
						st_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				if (!sent80_q) begin
					cmd.shift = 1'b1;
					cmd.src   = SRC_PAD80;
					sent80_d  = 1'b1;
					if (sts.pos_wrap) begin
						cmd.round_load = 1'b1;
						st_d           = ST_ROUND;
					end
				end else if (sts.pos_56) begin
					cmd.blen_load = 1'b1;
					st_d          = ST_LEN;
				end else begin
					cmd.shift = 1'b1;
					cmd.src   = SRC_ZERO;
					if (sts.pos_wrap) begin
						cmd.round_load = 1'b1;
						st_d           = ST_ROUND;
					end
				end
			end
			ST_LEN: begin
				cmd.shift = 1'b1;
				cmd.src   = SRC_LEN;
				if (sts.pos_wrap) begin
					cmd.round_load = 1'b1;
					fin_d          = 1'b1;
					st_d           = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				if (rnd_q == LAST_ROUND) begin
					rnd_d = '0;
					st_d  = ST_ADD;
				end else begin
					rnd_d = rnd_q + 7'd1;
				end
			end
			ST_ADD: begin
				cmd.chain_add = 1'b1;
				widx_d        = '0;
				if (fin_q) begin
					st_d = ST_OUT;
				end else if (pad_q) begin
					st_d = ST_PAD;
				end else begin
					st_d = ST_IDLE;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (widx_q == LAST_WIDX) begin
						cmd.chain_init = 1'b1;
						fin_d          = 1'b0;
						pad_d          = 1'b0;
						sent80_d       = 1'b0;
						widx_d         = '0;
						st_d           = ST_IDLE;
					end else begin
						widx_d = widx_q + 3'd1;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/shc_dp.sv @@
module shc_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  shc_pkg::cmd_t cmd,
	input  logic [7:0]    data_byte,
	output shc_pkg::sts_t sts,
	output logic [31:0]   digest_word
);
	import shc_pkg::*;

	// blk_q holds W[t..t+15], W[t] in the top word
	logic [511:0] blk_q;
	logic [5:0]   pos_q;
	logic [63:0]  len_q;
	logic [63:0]  blen_q;
	logic [31:0]  h_q [5];
	logic [31:0]  a_q, b_q, c_q, d_q, e_q;

	logic [7:0]  byte_in;
	logic [31:0] f, k, t, w_new;
	logic [31:0] w0, w2, w8, w13;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	assign w0  = blk_q[511:480];
	assign w2  = blk_q[447:416];
	assign w8  = blk_q[255:224];
	assign w13 = blk_q[95:64];
	assign w_new = rotl(w13 ^ w8 ^ w2 ^ w0, 1);

	always_comb begin
		unique case (cmd.src)
			SRC_DATA:  byte_in = data_byte;
			SRC_PAD80: byte_in = PAD_BYTE;
			SRC_ZERO:  byte_in = 8'h00;
			SRC_LEN:   byte_in = blen_q[63:56];
			default:   byte_in = 8'h00;
		endcase
	end

	always_comb begin
		unique case (cmd.phase)
			PH_CH: begin
				f = (b_q & c_q) | (~b_q & d_q);
				k = K0;
			end
			PH_PAR1: begin
				f = b_q ^ c_q ^ d_q;
				k = K1;
			end
			PH_MAJ: begin
				f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
				k = K2;
			end
			PH_PAR2: begin
				f = b_q ^ c_q ^ d_q;
				k = K3;
			end
			default: begin
				f = b_q ^ c_q ^ d_q;
				k = K3;
			end
		endcase
	end

	assign t = rotl(a_q, 5) + f + e_q + k + w0;

	assign sts.pos_wrap = (pos_q == END_POS);
	assign sts.pos_56   = (pos_q == LEN_POS);
	assign digest_word  = h_q[cmd.widx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			len_q  <= '0;
			h_q[0] <= IV0;
			h_q[1] <= IV1;
			h_q[2] <= IV2;
			h_q[3] <= IV3;
			h_q[4] <= IV4;
		end else begin
			if (cmd.shift) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.chain_init) begin
				len_q  <= '0;
				h_q[0] <= IV0;
				h_q[1] <= IV1;
				h_q[2] <= IV2;
				h_q[3] <= IV3;
				h_q[4] <= IV4;
			end else begin
				if (cmd.len_inc) begin
					len_q <= len_q + 64'd1;
				end
				if (cmd.chain_add) begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			blk_q <= {blk_q[503:0], byte_in};
		end else if (cmd.round_en) begin
			blk_q <= {blk_q[479:0], w_new};
		end
		if (cmd.blen_load) begin
			blen_q <= {len_q[60:0], 3'b000};
		end else if (cmd.shift && cmd.src == SRC_LEN) begin
			blen_q <= {blen_q[55:0], 8'h00};
		end
		if (cmd.round_load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (cmd.round_en) begin
			a_q <= t;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

@@ rtl/core/sha1_hash_core_top.sv @@
// Channel | Dir | tdata            | tuser           | tlast
// s_*     | in  | [7:0] data_byte  | [0] byte_valid  | last
// m_*     | out | [31:0] digest_w  | [2:0] word_index| last_word
//
// A byte item is taken while s_tready is high; the item completing a 64-byte block
// then runs the 80 rounds and the chaining add.
// On a last item, padding goes in at one byte a cycle, paused while a padded block runs its rounds,
// plus a length load step; then five digest words go out, one a cycle while m_tready is high.
// s_tready is low from the last item until the fifth word is taken.
// arst_n clears control, byte count and block position and loads the chaining value with the IV at once.
module sha1_hash_core_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tuser,  // [0] byte_valid
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] digest_word
	output logic [2:0]  m_tuser,  // [2:0] word_index
	output logic        m_tlast
);
	import shc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	shc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.byte_valid (s_tuser),
		.last       (s_tlast),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	shc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.data_byte   (s_tdata),
		.sts         (sts),
		.digest_word (m_tdata)
	);

	assign m_tuser = cmd.widx;
	assign m_tlast = (cmd.widx == LAST_WIDX);

endmodule

@@ rtl/core/shc_chk.sv @@
module shc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);
	import shc_pkg::*;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while digest pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled digest word changed");

	a_last_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == LAST_WIDX)))
		else $error("tlast not on word four");

	a_next_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser == $past(m_tuser) + 3'd1)
		else $error("digest words not consecutive");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
		else $error("not idle after last digest word");

endmodule

bind sha1_hash_core_top shc_chk u_shc_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
